### sv/atp_pkg.sv
// Package for the ATAPI task-file device: phase type, codes and identify table.
package atp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_IDENT,
		PH_CMD,
		PH_DATA
	} phase_t;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	localparam logic [2:0] REG_DATA   = 3'd0;
	localparam logic [2:0] REG_ERROR  = 3'd1;
	localparam logic [2:0] REG_COUNT  = 3'd2;
	localparam logic [2:0] REG_LBA_LO = 3'd3;
	localparam logic [2:0] REG_LBA_MD = 3'd4;
	localparam logic [2:0] REG_LBA_HI = 3'd5;
	localparam logic [2:0] REG_DEVICE = 3'd6;
	localparam logic [2:0] REG_STATUS = 3'd7;

	localparam logic [7:0] OP_RESET    = 8'h08;
	localparam logic [7:0] OP_IDENTIFY = 8'hEC;
	localparam logic [7:0] OP_IDENT_PK = 8'hA1;
	localparam logic [7:0] OP_PACKET   = 8'hA0;

	localparam logic [7:0] ST_RDY  = 8'h40;
	localparam logic [7:0] ST_DRQ  = 8'h08;
	localparam logic [7:0] ST_ERR  = 8'h01;
	localparam logic [7:0] ER_ABRT = 8'h04;
	localparam logic [7:0] SIG_MID = 8'h14;
	localparam logic [7:0] SIG_HI  = 8'hEB;
	localparam logic [7:0] DEV_SET = 8'hA0;
	localparam logic [15:0] BC_MAX = 16'hFFFE;

	// identify word as read on the bus (byte 2w high, byte 2w+1 low)
	function automatic logic [15:0] ident_word(input logic [7:0] w);
		logic [15:0] v;
		v = 16'h0000;
		if (w >= 8'd10 && w <= 8'd18) v = 16'h3030;
		if (w >= 8'd24 && w <= 8'd24) v = 16'h3030;
		if (w >= 8'd25 && w <= 8'd26) v = 16'h2020;
		if (w >= 8'd39 && w <= 8'd46) v = 16'h2020;
		unique case (w)
			8'd0:  v = 16'hC085;
			8'd2:  v = 16'h37C8;
			8'd19: v = 16'h3130;
			8'd23: v = 16'h2E31;
			8'd27: v = 16'h4542;
			8'd28: v = 16'h4C4C;
			8'd29: v = 16'h5441;
			8'd30: v = 16'h4952;
			8'd31: v = 16'h2058;
			8'd32: v = 16'h4956;
			8'd33: v = 16'h5452;
			8'd34: v = 16'h4155;
			8'd35: v = 16'h204C;
			8'd36: v = 16'h4443;
			8'd37: v = 16'h522D;
			8'd38: v = 16'h4D4F;
			8'd47: v = 16'h0180;
			8'd49: v = 16'h0002;
			8'd51: v = 16'h0002;
			8'd53: v = 16'h0600;
			8'd63: v = 16'h0700;
			8'd64: v = 16'h0100;
			8'd80: v = 16'hF000;
			8'd81: v = 16'h2200;
			default: ;
		endcase
		return v;
	endfunction

endpackage

### sv/atp_buffer.sv
// Transfer buffer: two byte-lane synchronous memories with a registered read.
module atp_buffer import atp_pkg::*; #(
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we_hi,
	input  logic          we_lo,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata_hi,
	input  logic [7:0]    wdata_lo,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [7:0] mem_hi [2**AW];
	logic [7:0] mem_lo [2**AW];
	logic [7:0] rd_hi_q;
	logic [7:0] rd_lo_q;

	always_ff @(posedge clk) begin
		if (we_hi) mem_hi[waddr] <= wdata_hi;
		if (re) rd_hi_q <= mem_hi[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_lo) mem_lo[waddr] <= wdata_lo;
		if (re) rd_lo_q <= mem_lo[raddr];
	end

	assign rdata = {rd_hi_q, rd_lo_q};

endmodule

### sv/atapi_task_file_device.sv
// ATAPI task-file device top level: register file, command decode, packet and data-in.
// A read request's result is registered and appears in the cycle after it is accepted.
// One request per cycle unless in_stall; a full packet holds the input until emitted.
// Data-in words: buffer port read at accept or identify table entry, registered once.
// Reset (arst_n low): task-file registers to signature values, phase idle, no result.
// Buffer and packet contents are not cleared; identify words are served from a table.
module atapi_task_file_device import atp_pkg::*; #(
	parameter int BUFFER_BYTES = 4096,
	parameter int PACKET_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  register_index,
	input  logic        wide_access,
	input  logic [15:0] write_data,
	input  logic [11:0] load_index,
	input  logic [7:0]  load_byte,
	input  logic        handler_error,
	input  logic [12:0] reply_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [15:0] read_data,
	output logic [7:0]  packet_byte,
	output logic        last_of_run
);

	localparam int LW  = $clog2(BUFFER_BYTES + 1);
	localparam int AW  = $clog2(BUFFER_BYTES / 2);
	localparam int PCW = $clog2(PACKET_BYTES + 1);
	localparam int PIW = $clog2(PACKET_BYTES);
	localparam int PWN = (PACKET_BYTES + 1) / 2;
	localparam int PWA = $clog2(PWN);

	logic           handler_q;
	logic [7:0]     err_q, st_q, feat_q, cnt_q, lba_lo_q, lba_md_q, lba_hi_q, dev_q;
	logic [7:0]     err_d, st_d, feat_d, cnt_d, lba_lo_d, lba_md_d, lba_hi_d, dev_d;
	phase_t         phase_q, phase_d;
	logic [LW-1:0]  len_q, len_d, pos_q, pos_d;
	logic [PCW-1:0] pkt_cnt_q, pkt_cnt_d;
	logic [255:0]   tbl_q, tbl_d;
	logic           emit_q, emit_d;
	logic [PIW-1:0] emit_idx_q, emit_idx_d;
	logic [15:0]    pkt_q [PWN];

	logic           s1_valid_s1, s1_kind_s1, s1_mem_s1, s1_last_s1;
	logic [15:0]    s1_val_s1;
	logic [7:0]     s1_pbyte_s1;
	logic           n_valid, n_kind, n_mem, n_last;
	logic [15:0]    n_val;
	logic [7:0]     n_pbyte;

	logic           accept, s1_free;
	logic           rd_en, we_hi, we_lo, pk_we;
	logic [AW-1:0]  rd_addr, wr_addr;
	logic [7:0]     wr_hi, wr_lo;
	logic [15:0]    rdata;
	logic [LW:0]    pos_p1, pos_p2, len_ext;
	logic [AW:0]    rd_word_ext, ld_word_ext;
	logic           rd_tbl, ld_tbl;
	logic [15:0]    rd_tbl_word, ld_tbl_word;
	logic [7:0]     lo_b, hi_b, byte_val;
	logic [PCW:0]   pc_p1;
	logic [LW:0]    rlen_c;
	logic [16:0]    bc;
	logic [15:0]    pk_word;

	assign s1_free  = !s1_valid_s1 || !out_stall;
	assign in_stall = emit_q || (s1_valid_s1 && out_stall);
	assign accept   = in_valid && !in_stall;

	assign lo_b = write_data[7:0];
	assign hi_b = write_data[15:8];

	assign pos_p1      = {1'b0, pos_q} + (LW+1)'(1);
	assign pos_p2      = {1'b0, pos_q} + (LW+1)'(2);
	assign len_ext     = {1'b0, len_q};
	assign rd_addr     = pos_q[AW:1];
	assign rd_word_ext = {1'b0, rd_addr};
	assign rd_tbl      = (rd_word_ext < (AW+1)'(256)) && tbl_q[8'(rd_addr)];
	assign rd_tbl_word = ident_word(8'(rd_addr));
	assign wr_addr     = AW'(load_index >> 1);
	assign ld_word_ext = {1'b0, wr_addr};
	assign ld_tbl      = (ld_word_ext < (AW+1)'(256)) && tbl_q[8'(wr_addr)];
	assign ld_tbl_word = ident_word(8'(wr_addr));
	assign pc_p1       = {1'b0, pkt_cnt_q} + (PCW+1)'(1);
	assign rlen_c      = (32'(reply_length) > BUFFER_BYTES) ? (LW+1)'(BUFFER_BYTES)
	                                                        : (LW+1)'(reply_length);
	assign bc          = (17'(rlen_c) > 17'(BC_MAX)) ? 17'(BC_MAX) : 17'(rlen_c);
	assign pk_word     = pkt_q[PWA'(emit_idx_q >> 1)];

	always_comb begin
		unique case (register_index)
			REG_ERROR:  byte_val = err_q;
			REG_COUNT:  byte_val = cnt_q;
			REG_LBA_LO: byte_val = lba_lo_q;
			REG_LBA_MD: byte_val = lba_md_q;
			REG_LBA_HI: byte_val = lba_hi_q;
			REG_DEVICE: byte_val = dev_q | DEV_SET;
			REG_STATUS: byte_val = st_q;
			default:    byte_val = 8'hFF;
		endcase
	end

	always_comb begin
		err_d = err_q; st_d = st_q; feat_d = feat_q; cnt_d = cnt_q;
		lba_lo_d = lba_lo_q; lba_md_d = lba_md_q; lba_hi_d = lba_hi_q; dev_d = dev_q;
		phase_d = phase_q; len_d = len_q; pos_d = pos_q; pkt_cnt_d = pkt_cnt_q;
		tbl_d = tbl_q; emit_d = emit_q; emit_idx_d = emit_idx_q;
		n_valid = 1'b0; n_kind = 1'b0; n_mem = 1'b0; n_last = 1'b1;
		n_val = 16'hFFFF; n_pbyte = 8'h00;
		rd_en = 1'b0; we_hi = 1'b0; we_lo = 1'b0; pk_we = 1'b0;
		wr_hi = load_byte; wr_lo = load_byte;
		if (accept) begin
			unique case (command)
				CMD_READ: begin
					n_valid = 1'b1;
					if (wide_access && register_index == REG_DATA) begin
						if ((phase_q == PH_IDENT || phase_q == PH_DATA) && pos_p1 < len_ext) begin
							rd_en = 1'b1;
							n_mem = !rd_tbl;
							n_val = rd_tbl_word;
							pos_d = LW'(pos_p2);
							if (pos_p2 >= len_ext) begin
								if (phase_q == PH_DATA) cnt_d = 8'h03;
								phase_d = PH_IDLE;
								st_d = ST_RDY;
								len_d = '0;
								pos_d = '0;
							end
						end
					end else begin
						n_val = {8'h00, byte_val};
					end
				end
				CMD_WRITE: begin
					unique case (register_index)
						REG_DATA: begin
							if (wide_access && phase_q == PH_CMD &&
							    32'(pkt_cnt_q) < PACKET_BYTES) begin
								pk_we = 1'b1;
								if (32'(pc_p1) < PACKET_BYTES)
									pkt_cnt_d = PCW'(pkt_cnt_q + PCW'(2));
								else
									pkt_cnt_d = PCW'(pc_p1);
								if (32'(pkt_cnt_d) >= PACKET_BYTES) begin
									if (!handler_q) begin
										err_d = ER_ABRT;
										st_d = ST_RDY | ST_ERR;
										phase_d = PH_IDLE;
									end else begin
										emit_d = 1'b1;
										emit_idx_d = '0;
									end
								end
							end
						end
						REG_ERROR:  feat_d = lo_b;
						REG_COUNT:  cnt_d = lo_b;
						REG_LBA_LO: lba_lo_d = lo_b;
						REG_LBA_MD: lba_md_d = lo_b;
						REG_LBA_HI: lba_hi_d = lo_b;
						REG_DEVICE: dev_d = lo_b;
						REG_STATUS: begin
							unique case (lo_b)
								OP_RESET: begin
									err_d = 8'h01; st_d = ST_RDY; feat_d = 8'h00; cnt_d = 8'h00;
									lba_lo_d = 8'h00; lba_md_d = SIG_MID; lba_hi_d = SIG_HI;
									dev_d = 8'h00; phase_d = PH_IDLE; len_d = '0; pos_d = '0;
									pkt_cnt_d = '0;
								end
								OP_IDENTIFY: begin
									lba_md_d = SIG_MID; lba_hi_d = SIG_HI;
									err_d = ER_ABRT; st_d = ST_RDY | ST_ERR;
								end
								OP_IDENT_PK: begin
									tbl_d = '1;
									len_d = LW'(512); pos_d = '0;
									phase_d = PH_IDENT; st_d = ST_RDY | ST_DRQ; err_d = 8'h00;
									lba_md_d = 8'h00; lba_hi_d = 8'h02;
								end
								OP_PACKET: begin
									phase_d = PH_CMD; pkt_cnt_d = '0; st_d = ST_RDY | ST_DRQ;
									err_d = 8'h00; cnt_d = 8'h01;
								end
								default: begin
									err_d = ER_ABRT; st_d = ST_RDY | ST_ERR;
								end
							endcase
						end
						default: ;
					endcase
				end
				CMD_LOAD: begin
					if (32'(load_index) < BUFFER_BYTES) begin
						if (ld_tbl) begin
							we_hi = 1'b1; we_lo = 1'b1;
							wr_hi = load_index[0] ? ld_tbl_word[15:8] : load_byte;
							wr_lo = load_index[0] ? load_byte : ld_tbl_word[7:0];
							tbl_d[8'(wr_addr)] = 1'b0;
						end else begin
							we_hi = !load_index[0];
							we_lo = load_index[0];
						end
					end
				end
				CMD_DONE: begin
					if (phase_q == PH_CMD && 32'(pkt_cnt_q) >= PACKET_BYTES) begin
						if (handler_error || reply_length == 13'd0) begin
							phase_d = PH_IDLE;
							st_d = handler_error ? (ST_RDY | ST_ERR) : ST_RDY;
							if (handler_error) err_d = ER_ABRT;
							cnt_d = 8'h03;
						end else begin
							len_d = LW'(rlen_c); pos_d = '0; phase_d = PH_DATA;
							st_d = ST_RDY | ST_DRQ; err_d = 8'h00;
							lba_md_d = bc[7:0]; lba_hi_d = bc[15:8]; cnt_d = 8'h02;
						end
					end
				end
				default: ;
			endcase
		end else if (emit_q && s1_free) begin
			n_valid = 1'b1;
			n_kind = 1'b1;
			n_val = 16'h0000;
			n_pbyte = emit_idx_q[0] ? pk_word[7:0] : pk_word[15:8];
			n_last = 32'(emit_idx_q) == PACKET_BYTES - 1;
			emit_idx_d = PIW'(emit_idx_q + PIW'(1));
			if (n_last) emit_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handler_q <= 1'b1;
			err_q <= 8'h01; st_q <= ST_RDY; feat_q <= 8'h00; cnt_q <= 8'h00;
			lba_lo_q <= 8'h00; lba_md_q <= SIG_MID; lba_hi_q <= SIG_HI; dev_q <= 8'h00;
			phase_q <= PH_IDLE; len_q <= '0; pos_q <= '0; pkt_cnt_q <= '0;
			tbl_q <= '0; emit_q <= 1'b0; emit_idx_q <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) handler_q <= cfg_wdata;
			err_q <= err_d; st_q <= st_d; feat_q <= feat_d; cnt_q <= cnt_d;
			lba_lo_q <= lba_lo_d; lba_md_q <= lba_md_d; lba_hi_q <= lba_hi_d; dev_q <= dev_d;
			phase_q <= phase_d; len_q <= len_d; pos_q <= pos_d; pkt_cnt_q <= pkt_cnt_d;
			tbl_q <= tbl_d; emit_q <= emit_d; emit_idx_q <= emit_idx_d;
			if (n_valid) s1_valid_s1 <= 1'b1;
			else if (!out_stall) s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (n_valid) begin
			s1_kind_s1 <= n_kind; s1_mem_s1 <= n_mem; s1_last_s1 <= n_last;
			s1_val_s1 <= n_val; s1_pbyte_s1 <= n_pbyte;
		end
		if (pk_we) pkt_q[PWA'(pkt_cnt_q >> 1)] <= {hi_b, lo_b};
	end

	atp_buffer #(.AW(AW)) u_buf (
		.clk      (clk),
		.we_hi    (we_hi),
		.we_lo    (we_lo),
		.waddr    (wr_addr),
		.wdata_hi (wr_hi),
		.wdata_lo (wr_lo),
		.re       (rd_en),
		.raddr    (rd_addr),
		.rdata    (rdata)
	);

	assign out_valid   = s1_valid_s1;
	assign result_kind = s1_kind_s1;
	assign read_data   = s1_kind_s1 ? 16'h0000 : (s1_mem_s1 ? rdata : s1_val_s1);
	assign packet_byte = s1_kind_s1 ? s1_pbyte_s1 : 8'h00;
	assign last_of_run = s1_last_s1;

	a_emit_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> in_stall) else $error("input taken during packet emission");
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> (phase_q == PH_CMD && 32'(pkt_cnt_q) >= PACKET_BYTES))
		else $error("emission outside full packet");
	a_pos_even: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_q[0]) else $error("odd transfer position");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && out_stall |=> s1_valid_s1) else $error("stalled result dropped");

endmodule

### bench/atapi_task_file_device_tb.sv
// Self-checking bench for the ATAPI task-file device: register access, commands, packet and data-in.
module atapi_task_file_device_tb;
	import atp_pkg::*;

	typedef struct {
		logic [1:0]  cmd;
		logic [2:0]  ri;
		logic        wide;
		logic [15:0] wd;
		logic [11:0] li;
		logic [7:0]  lb;
		logic        herr;
		logic [12:0] rlen;
	} req_t;

	typedef struct {
		logic        kind;
		logic [15:0] rd;
		logic [7:0]  pb;
		logic        last;
	} res_t;

	localparam int BUF_BYTES = 4096;
	localparam int PKT_BYTES = 12;
	localparam logic [159:0] SERIAL_TXT = "00000000000000000001";
	localparam logic [63:0] FW_TXT = "1.00    ";
	localparam logic [319:0] MODEL_TXT = {72'h42454C4C4154524958, " VIRTUAL CD-ROM                "};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [2:0] register_index = '0;
	logic wide_access = 1'b0;
	logic [15:0] write_data = '0;
	logic [11:0] load_index = '0;
	logic [7:0] load_byte = '0;
	logic handler_error = 1'b0;
	logic [12:0] reply_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [15:0] read_data;
	logic [7:0] packet_byte;
	logic last_of_run;

	// device state as predicted
	logic handler_on;
	logic [7:0] err_r, stat_r, feat_r, cnt_r, lbal_r, lbam_r, lbah_r, dev_r;
	phase_t ph;
	int data_len, data_pos, pkt_cnt;
	logic [7:0] pkt_bytes [PKT_BYTES];
	logic [7:0] buf_mem [BUF_BYTES];
	bit buf_known [BUF_BYTES];

	res_t expected_results [$];
	int errors = 0, n_sent = 0, n_checked = 0, n_packets = 0, n_words = 0;
	int hold_left = 0;
	bit no_gaps = 0;
	bit quiet_rx = 0;

	atapi_task_file_device dut (.*);

	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("atapi_task_file_device_tb: errors");
		$finish;
	end

	task automatic reset_regs();
		err_r = 8'h01; stat_r = ST_RDY; feat_r = 8'h00; cnt_r = 8'h00; lbal_r = 8'h00;
		lbam_r = SIG_MID; lbah_r = SIG_HI; dev_r = 8'h00; ph = PH_IDLE;
		data_len = 0; data_pos = 0; pkt_cnt = 0;
	endtask

	task automatic put_word(int w, logic [15:0] v);
		buf_mem[2*w] = v[7:0];
		buf_mem[2*w+1] = v[15:8];
	endtask

	task automatic load_identify();
		for (int i = 0; i < 512; i++) begin
			buf_mem[i] = 8'h00;
			buf_known[i] = 1'b1;
		end
		put_word(0, 16'h85C0);
		put_word(2, 16'hC837);
		for (int i = 0; i < 20; i++)
			buf_mem[20 + (i ^ 1)] = SERIAL_TXT[159 - 8*i -: 8];
		for (int i = 0; i < 8; i++)
			buf_mem[46 + (i ^ 1)] = FW_TXT[63 - 8*i -: 8];
		for (int i = 0; i < 40; i++)
			buf_mem[54 + (i ^ 1)] = MODEL_TXT[319 - 8*i -: 8];
		put_word(47, 16'h8001);
		put_word(49, 16'h0200);
		put_word(51, 16'h0200);
		put_word(53, 16'h0006);
		put_word(63, 16'h0007);
		put_word(64, 16'h0001);
		put_word(80, 16'h00F0);
		put_word(81, 16'h0022);
		data_len = 512;
		data_pos = 0;
	endtask

	task automatic run_op(logic [7:0] op);
		case (op)
			OP_RESET: reset_regs();
			OP_IDENTIFY: begin
				lbam_r = SIG_MID; lbah_r = SIG_HI; err_r = ER_ABRT; stat_r = ST_RDY | ST_ERR;
			end
			OP_IDENT_PK: begin
				load_identify();
				ph = PH_IDENT; stat_r = ST_RDY | ST_DRQ; err_r = 8'h00; lbam_r = 8'h00;
				lbah_r = 8'h02;
			end
			OP_PACKET: begin
				ph = PH_CMD; pkt_cnt = 0; stat_r = ST_RDY | ST_DRQ; err_r = 8'h00; cnt_r = 8'h01;
			end
			default: begin
				err_r = ER_ABRT; stat_r = ST_RDY | ST_ERR;
			end
		endcase
	endtask

	function automatic logic [7:0] reg_byte(logic [2:0] ri);
		case (ri)
			REG_ERROR: return err_r;
			REG_COUNT: return cnt_r;
			REG_LBA_LO: return lbal_r;
			REG_LBA_MD: return lbam_r;
			REG_LBA_HI: return lbah_r;
			REG_DEVICE: return dev_r | DEV_SET;
			REG_STATUS: return stat_r;
			default: return 8'hFF;
		endcase
	endfunction

	task automatic next_data_word(output logic [15:0] w);
		w = 16'hFFFF;
		if ((ph == PH_IDENT || ph == PH_DATA) && data_pos + 1 < data_len) begin
			w = {buf_mem[data_pos], buf_mem[data_pos+1]};
			data_pos += 2;
			n_words++;
			if (data_pos >= data_len) begin
				if (ph == PH_DATA)
					cnt_r = 8'h03;
				ph = PH_IDLE; stat_r = ST_RDY; data_len = 0; data_pos = 0;
			end
		end
	endtask

	// a data read here would not touch a never-loaded buffer byte
	function automatic bit data_read_defined();
		if (!(ph == PH_IDENT || ph == PH_DATA) || !(data_pos + 1 < data_len))
			return 1'b1;
		return buf_known[data_pos] && buf_known[data_pos+1];
	endfunction

	task automatic predict_taskfile(req_t r);
		res_t e;
		logic [15:0] v;
		int bc;
		case (r.cmd)
			CMD_READ: begin
				if (r.wide && r.ri == REG_DATA)
					next_data_word(v);
				else
					v = {8'h00, reg_byte(r.ri)};
				e.kind = 1'b0; e.rd = v; e.pb = 8'h00; e.last = 1'b1;
				expected_results.push_back(e);
			end
			CMD_WRITE: begin
				if (r.ri != REG_DATA) begin
					case (r.ri)
						REG_ERROR: feat_r = r.wd[7:0];
						REG_COUNT: cnt_r = r.wd[7:0];
						REG_LBA_LO: lbal_r = r.wd[7:0];
						REG_LBA_MD: lbam_r = r.wd[7:0];
						REG_LBA_HI: lbah_r = r.wd[7:0];
						REG_DEVICE: dev_r = r.wd[7:0];
						default: run_op(r.wd[7:0]);
					endcase
				end else if (r.wide && ph == PH_CMD && pkt_cnt < PKT_BYTES) begin
					pkt_bytes[pkt_cnt++] = r.wd[15:8];
					if (pkt_cnt < PKT_BYTES)
						pkt_bytes[pkt_cnt++] = r.wd[7:0];
					if (pkt_cnt == PKT_BYTES) begin
						if (!handler_on) begin
							err_r = ER_ABRT; stat_r = ST_RDY | ST_ERR; ph = PH_IDLE;
						end else begin
							n_packets++;
							for (int k = 0; k < PKT_BYTES; k++) begin
								e.kind = 1'b1; e.rd = 16'h0000; e.pb = pkt_bytes[k];
								e.last = (k == PKT_BYTES - 1);
								expected_results.push_back(e);
							end
						end
					end
				end
			end
			CMD_LOAD: begin
				buf_mem[r.li] = r.lb;
				buf_known[r.li] = 1'b1;
			end
			default: begin
				if (ph == PH_CMD && pkt_cnt >= PKT_BYTES) begin
					if (r.herr || r.rlen == 13'd0) begin
						ph = PH_IDLE;
						stat_r = ST_RDY | (r.herr ? ST_ERR : 8'h00);
						if (r.herr)
							err_r = ER_ABRT;
						cnt_r = 8'h03;
					end else begin
						bc = (r.rlen > BUF_BYTES) ? BUF_BYTES : int'(r.rlen);
						data_len = bc; data_pos = 0; ph = PH_DATA;
						stat_r = ST_RDY | ST_DRQ; err_r = 8'h00;
						lbam_r = bc[7:0]; lbah_r = bc[15:8]; cnt_r = 8'h02;
					end
				end
			end
		endcase
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_gaps || p < 60)
			return 0;
		if (p < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_request(req_t r);
		bit taken;
		int gap;
		in_valid <= 1'b1;
		command <= r.cmd; register_index <= r.ri; wide_access <= r.wide;
		write_data <= r.wd; load_index <= r.li; load_byte <= r.lb;
		handler_error <= r.herr; reply_length <= r.rlen;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_taskfile(r);
		n_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic req_t mk(logic [1:0] c, logic [2:0] ri, logic w, logic [15:0] d);
		req_t r;
		r.cmd = c; r.ri = ri; r.wide = w; r.wd = d;
		r.li = 12'($urandom); r.lb = 8'($urandom); r.herr = 1'($urandom);
		r.rlen = 13'($urandom);
		return r;
	endfunction

	function automatic req_t mk_done(logic herr, logic [12:0] len);
		req_t r;
		r = mk(CMD_DONE, 3'($urandom), 1'($urandom), 16'($urandom));
		r.herr = herr; r.rlen = len;
		return r;
	endfunction

	task automatic rd(logic [2:0] ri, logic w);
		send_request(mk(CMD_READ, ri, w, 16'($urandom)));
	endtask

	task automatic wr(logic [2:0] ri, logic w, logic [15:0] d);
		send_request(mk(CMD_WRITE, ri, w, d));
	endtask

	task automatic load(int idx, logic [7:0] b);
		req_t r;
		r = mk(CMD_LOAD, 3'($urandom), 1'($urandom), 16'($urandom));
		r.li = 12'(idx); r.lb = b;
		send_request(r);
	endtask

	task automatic data_read();
		if (data_read_defined())
			rd(REG_DATA, 1'b1);
		else
			rd(REG_STATUS, 1'b0);
	endtask

	task automatic send_packet();
		wr(REG_STATUS, 1'($urandom), {8'($urandom_range(0, 255)), OP_PACKET});
		for (int i = 0; i < PKT_BYTES / 2; i++)
			wr(REG_DATA, 1'b1, 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_handler(logic v);
		drain();
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		handler_on = v;
	endtask

	task automatic test_registers();
		for (int i = 0; i < 8; i++)
			rd(3'(i), i[0]);
		rd(REG_DATA, 1'b1);
		for (int i = 1; i < 7; i++)
			wr(3'(i), i[0], 16'hFFFF);
		wr(REG_DATA, 1'b0, 16'h1234);
		for (int i = 1; i < 7; i++)
			rd(3'(i), 1'b0);
		wr(REG_LBA_LO, 1'b0, 16'hFF00);
		rd(REG_LBA_LO, 1'b1);
		wr(REG_STATUS, 1'b0, {8'h00, OP_IDENTIFY});
		rd(REG_STATUS, 1'b0);
		send_request(mk_done(1'b0, 13'd8));
		wr(REG_STATUS, 1'b0, 16'h0055);
		rd(REG_ERROR, 1'b0);
		wr(REG_STATUS, 1'b0, {8'hFF, OP_RESET});
		rd(REG_LBA_HI, 1'b0);
	endtask

	task automatic test_identify();
		wr(REG_STATUS, 1'b0, {8'h00, OP_IDENT_PK});
		rd(REG_LBA_HI, 1'b0);
		for (int i = 0; i < 84; i++)
			rd(REG_DATA, 1'b1);
		rd(REG_STATUS, 1'b0);
		wr(REG_STATUS, 1'b0, {8'h00, OP_RESET});
	endtask

	task automatic test_packet();
		for (int i = 0; i < 16; i++)
			load(i, 8'($urandom));
		load(BUF_BYTES - 1, 8'hFF);
		load(16, 8'h00);
		send_packet();
		wr(REG_DATA, 1'b1, 16'hFFFF);
		send_request(mk_done(1'b0, 13'd7));
		rd(REG_LBA_MD, 1'b0);
		for (int i = 0; i < 5; i++)
			data_read();
		rd(REG_COUNT, 1'b0);
		send_packet();
		send_request(mk_done(1'b1, 13'd40));
		rd(REG_ERROR, 1'b0);
		send_packet();
		send_request(mk_done(1'b0, 13'd0));
		rd(REG_COUNT, 1'b0);
		send_packet();
		send_request(mk_done(1'b0, 13'h1FFF));
		rd(REG_LBA_HI, 1'b0);
		data_read();
		wr(REG_STATUS, 1'b0, {8'h00, OP_RESET});
		send_packet();
		send_request(mk_done(1'b0, 13'd4096));
		rd(REG_LBA_MD, 1'b0);
		wr(REG_STATUS, 1'b0, {8'h00, OP_PACKET});
		wr(REG_DATA, 1'b1, 16'hA5A5);
		wr(REG_STATUS, 1'b0, {8'h00, OP_RESET});
	endtask

	task automatic test_no_handler();
		set_handler(1'b0);
		send_packet();
		rd(REG_STATUS, 1'b0);
		send_request(mk_done(1'b0, 13'd4));
		rd(REG_ERROR, 1'b0);
		set_handler(1'b1);
		send_packet();
		send_request(mk_done(1'b0, 13'd2));
		data_read();
	endtask

	task automatic test_backpressure();
		drain();
		hold_left = 80;
		for (int i = 0; i < 3; i++)
			send_packet();
		for (int i = 0; i < 20; i++)
			rd(3'($urandom), 1'($urandom));
		drain();
		hold_left = 40;
		no_gaps = 1;
		for (int i = 0; i < 20; i++)
			rd(3'($urandom), 1'($urandom));
		no_gaps = 0;
		drain();
	endtask

	task automatic test_random(int count);
		req_t r;
		int start;
		start = n_sent;
		while (n_sent - start < count) begin
			if (($urandom_range(0, 9) == 0))
				no_gaps = !no_gaps;
			quiet_rx = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) < 4) begin
				send_packet();
				if ($urandom_range(0, 5) == 0)
					wr(REG_DATA, 1'($urandom), 16'($urandom));
				case ($urandom_range(0, 9))
					0: send_request(mk_done(1'b1, 13'($urandom)));
					1: send_request(mk_done(1'b0, 13'd0));
					2: send_request(mk_done(1'b0, 13'($urandom)));
					default: send_request(mk_done(1'b0, 13'($urandom_range(1, 40))));
				endcase
				rd(3'($urandom_range(1, 7)), 1'b0);
				repeat ($urandom_range(0, 12))
					data_read();
			end else begin
				r = mk(2'($urandom), 3'($urandom), 1'($urandom), 16'($urandom));
				if (r.cmd == CMD_LOAD && $urandom_range(0, 1))
					r.li = 12'($urandom_range(0, 63));
				if (r.cmd == CMD_READ && r.wide && r.ri == REG_DATA && !data_read_defined())
					r.ri = REG_LBA_LO;
				send_request(r);
			end
		end
		no_gaps = 0;
		quiet_rx = 0;
	endtask

	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else begin
				out_stall <= 1'b0;
				if (!quiet_rx && $urandom_range(0, 4) == 0)
					burst = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(negedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result kind=%0d data=%h byte=%h", result_kind, read_data,
					packet_byte);
				errors++;
			end else begin
				e = expected_results.pop_front();
				n_checked++;
				if (result_kind !== e.kind) begin
					$error("result_kind: expected %0d, got %0d", e.kind, result_kind);
					errors++;
				end
				if (read_data !== e.rd) begin
					$error("read_data: expected %h, got %h", e.rd, read_data);
					errors++;
				end
				if (packet_byte !== e.pb) begin
					$error("packet_byte: expected %h, got %h", e.pb, packet_byte);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		handler_on = 1'b1;
		reset_regs();
		for (int i = 0; i < BUF_BYTES; i++) begin
			buf_mem[i] = 8'h00;
			buf_known[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_registers();
		test_identify();
		test_packet();
		test_no_handler();
		test_backpressure();
		test_random(60);
		in_valid <= 1'b0;
		drain();
		repeat (10) @(posedge clk);
		$display("ran %0d requests, checked %0d results (%0d packets, %0d data words)",
			n_sent, n_checked, n_packets, n_words);
		if (errors == 0 && expected_results.size() == 0)
			$display("atapi_task_file_device_tb: clean");
		else
			$display("atapi_task_file_device_tb: errors");
		$finish;
	end

endmodule
